FILE: hdl/arff_pkg.sv
package arff_pkg;

  // Default grid edge length in blocks
  localparam int unsigned GRID_BLOCKS_DEF = 64;

  // Field widths of the request and result items
  localparam int unsigned SIZE_W = 7;
  localparam int unsigned POS_W  = 6;

  // Packed stream widths, padded to whole bytes
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 16;

  // Request kinds carried on the slave tuser
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

endpackage

FILE: hdl/atlas_rect_first_fit_allocator_core.sv
// Channel   Dir  Accept              Payload
// s_axis    in   tvalid && tready    tuser: req_type; tdata: rect_w, rect_h, pos_x, pos_y
// m_axis    out  tvalid && tready    tdata: granted, corner_x, corner_y
//
// Flow: one transaction at a time. An allocate reads the occupancy memory row by row for every
// candidate row tried and erodes the free runs one column per cycle, then marks the rectangle;
// a release reads and rewrites the rectangle's rows in the same way to clear it.
// Reset: per-row valid flags clear at once, so the map reads as all free right after reset.
// Stalls: a finished result waits in the output register while the next request is taken;
// the core stalls only when a second result is ready before the first one has left.
module atlas_rect_first_fit_allocator_core #(
  parameter int unsigned GRID_BLOCKS = arff_pkg::GRID_BLOCKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: rect_w[6:0], rect_h[13:7], pos_x[19:14], pos_y[25:20], zero pad
  input  logic [arff_pkg::S_DATA_W-1:0] s_axis_tdata,
  // tuser: req_type[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: granted[0], corner_x[6:1], corner_y[12:7], zero pad
  output logic [arff_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import arff_pkg::*;

  localparam int unsigned IW = (GRID_BLOCKS > 1) ? $clog2(GRID_BLOCKS) : 1;
  localparam int unsigned CW = IW + 1;
  localparam int unsigned SW = ((CW > SIZE_W) ? CW : SIZE_W) + 1;
  localparam int unsigned XW = (IW > POS_W) ? IW : POS_W;
  localparam logic [SW-1:0] GRID_S = SW'(GRID_BLOCKS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ACC   = 7'b0000010,
    S_ERODE = 7'b0000100,
    S_ISO   = 7'b0001000,
    S_PICK  = 7'b0010000,
    S_MASK  = 7'b0100000,
    S_PAINT = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // Request registers
  logic              req_q, req_d;
  logic [SIZE_W-1:0] w_q, w_d;
  logic [SIZE_W-1:0] h_q, h_d;
  logic [XW-1:0]     x_q, x_d;
  logic [XW-1:0]     y_q, y_d;

  // Row sweep over the memory
  logic [SW-1:0]          rd_next_q, rd_next_d;
  logic [SW-1:0]          rd_end_q, rd_end_d;
  logic                   rd_pend_q;
  logic [IW-1:0]          rd_row_q;
  logic                   rd_go;
  logic [IW-1:0]          rd_addr;

  // Search and paint datapath
  logic [GRID_BLOCKS-1:0] acc_q, acc_d;
  logic [GRID_BLOCKS-1:0] fits_q, fits_d;
  logic [GRID_BLOCKS-1:0] low_q, low_d;
  logic [GRID_BLOCKS-1:0] mask_q, mask_d;
  logic [SIZE_W-1:0]      er_q, er_d;
  logic [IW-1:0]          low_idx;
  logic [SW-1:0]          ny_s;
  logic [SW-1:0]          yend_s;
  logic [SW-1:0]          xend_s;

  // Result staging and output register
  logic              res_g_q, res_g_d;
  logic [POS_W-1:0]  res_x_q, res_x_d;
  logic [POS_W-1:0]  res_y_q, res_y_d;
  logic              out_vld_q;
  logic              out_g_q;
  logic [POS_W-1:0]  out_x_q;
  logic [POS_W-1:0]  out_y_q;
  logic              out_load;

  // Occupancy memory
  logic [GRID_BLOCKS-1:0] mem [GRID_BLOCKS];
  logic [GRID_BLOCKS-1:0] row_vld_q;
  logic [GRID_BLOCKS-1:0] mem_rdata_q;
  logic                   rd_vld_q;
  logic [GRID_BLOCKS-1:0] rdata_eff;
  logic                   mem_we;
  logic [GRID_BLOCKS-1:0] mem_wdata;

  logic [SIZE_W-1:0] in_w;
  logic [SIZE_W-1:0] in_h;
  logic [POS_W-1:0]  in_x;
  logic [POS_W-1:0]  in_y;
  logic              s_fire;

  assign in_w   = s_axis_tdata[6:0];
  assign in_h   = s_axis_tdata[13:7];
  assign in_x   = s_axis_tdata[19:14];
  assign in_y   = s_axis_tdata[25:20];
  assign s_axis_tready = (state_q == S_IDLE) && !done_q;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // Issue one row read per cycle while the sweep has rows left
  assign rd_go   = ((state_q == S_ACC) || (state_q == S_PAINT)) && (rd_next_q < rd_end_q);
  assign rd_addr = rd_next_q[IW-1:0];
  assign rdata_eff = rd_vld_q ? mem_rdata_q : '0;
  assign mem_we    = (state_q == S_PAINT) && rd_pend_q;
  assign mem_wdata = req_q ? (rdata_eff & ~mask_q) : (rdata_eff | mask_q);

  // Encode the isolated lowest free corner
  always_comb begin
    low_idx = '0;
    for (int c = 0; c < GRID_BLOCKS; c++) begin
      low_idx = low_idx | (low_q[c] ? IW'(c) : '0);
    end
  end

  assign ny_s   = SW'(y_q) + SW'(1);
  assign yend_s = SW'(y_q) + SW'(h_q);
  assign xend_s = SW'(x_q) + SW'(w_q);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    done_d    = done_q;
    req_d     = req_q;
    w_d       = w_q;
    h_d       = h_q;
    x_d       = x_q;
    y_d       = y_q;
    rd_next_d = rd_next_q;
    rd_end_d  = rd_end_q;
    acc_d     = acc_q;
    fits_d    = fits_q;
    low_d     = low_q;
    mask_d    = mask_q;
    er_d      = er_q;
    res_g_d   = res_g_q;
    res_x_d   = res_x_q;
    res_y_d   = res_y_q;

    if (rd_go) begin
      rd_next_d = rd_next_q + SW'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          req_d = s_axis_tuser;
          w_d   = in_w;
          h_d   = in_h;
          if (s_axis_tuser == REQ_RELEASE) begin
            x_d     = XW'(in_x);
            y_d     = XW'(in_y);
            state_d = S_MASK;
          end else if ((in_w == '0) || (in_h == '0) || (SW'(in_w) > GRID_S) ||
                       (SW'(in_h) > GRID_S)) begin
            res_g_d = 1'b0;
            res_x_d = '0;
            res_y_d = '0;
            done_d  = 1'b1;
          end else begin
            y_d       = '0;
            rd_next_d = '0;
            rd_end_d  = SW'(in_h);
            acc_d     = '0;
            state_d   = S_ACC;
          end
        end
      end
      S_ACC: begin
        // Gather the busy columns of the candidate band
        if (rd_pend_q) begin
          acc_d = acc_q | rdata_eff;
        end
        if (!rd_go && !rd_pend_q) begin
          fits_d  = ~acc_q;
          er_d    = SIZE_W'(1);
          state_d = S_ERODE;
        end
      end
      S_ERODE: begin
        // Shrink free runs by one column per step until each set bit starts w free columns
        if (er_q < w_q) begin
          fits_d = fits_q & (fits_q >> 1);
          er_d   = er_q + SIZE_W'(1);
        end else begin
          state_d = S_ISO;
        end
      end
      S_ISO: begin
        low_d   = fits_q & (~fits_q + GRID_BLOCKS'(1));
        state_d = S_PICK;
      end
      S_PICK: begin
        if (low_q != '0) begin
          x_d     = XW'(low_idx);
          state_d = S_MASK;
        end else if (ny_s + SW'(h_q) <= GRID_S) begin
          y_d       = XW'(ny_s);
          rd_next_d = ny_s;
          rd_end_d  = ny_s + SW'(h_q);
          acc_d     = '0;
          state_d   = S_ACC;
        end else begin
          res_g_d = 1'b0;
          res_x_d = '0;
          res_y_d = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_MASK: begin
        // Build the column mask and the clipped row range
        for (int c = 0; c < GRID_BLOCKS; c++) begin
          mask_d[c] = (SW'(c) >= SW'(x_q)) && (SW'(c) < xend_s);
        end
        rd_next_d = SW'(y_q);
        rd_end_d  = (yend_s > GRID_S) ? GRID_S : yend_s;
        state_d   = S_PAINT;
      end
      S_PAINT: begin
        if (!rd_go && !rd_pend_q) begin
          res_g_d = 1'b1;
          res_x_d = x_q[POS_W-1:0];
          res_y_d = y_q[POS_W-1:0];
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Hand the result over once the output register is free
    if (done_q && out_load) begin
      done_d = 1'b0;
    end
  end

  assign out_load = !out_vld_q || m_axis_tready;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      rd_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      rd_pend_q <= rd_go;
      if (done_q && out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (mem_we) begin
        row_vld_q[rd_row_q] <= 1'b1;
      end
      if (rd_go) begin
        rd_vld_q <= row_vld_q[rd_addr];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    w_q       <= w_d;
    h_q       <= h_d;
    x_q       <= x_d;
    y_q       <= y_d;
    rd_next_q <= rd_next_d;
    rd_end_q  <= rd_end_d;
    acc_q     <= acc_d;
    fits_q    <= fits_d;
    low_q     <= low_d;
    mask_q    <= mask_d;
    er_q      <= er_d;
    res_g_q   <= res_g_d;
    res_x_q   <= res_x_d;
    res_y_q   <= res_y_d;
    if (rd_go) begin
      rd_row_q <= rd_addr;
    end
    if (done_q && out_load) begin
      out_g_q <= res_g_q;
      out_x_q <= res_x_q;
      out_y_q <= res_y_q;
    end
  end

  // Occupancy memory, one row word per entry
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[rd_row_q] <= mem_wdata;
    end
    if (rd_go) begin
      mem_rdata_q <= mem[rd_addr];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = M_DATA_W'({out_y_q, out_x_q, out_g_q});

`ifndef SYNTHESIS
  // Writes only happen in the paint phase, which marks or clears a rectangle
  a_write_in_paint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_PAINT))
    else $error("occupancy write outside paint phase");

  // Reads stay inside the grid
  a_read_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_go |-> (rd_next_q < GRID_S))
    else $error("occupancy read beyond grid");

  // Returned read data is consumed by a sweep state
  a_pend_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> ((state_q == S_ACC) || (state_q == S_PAINT)))
    else $error("read data returned with no sweep active");

  // A staged result reaches the free output register on the next cycle
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !out_vld_q) |=> (out_vld_q && !done_q))
    else $error("staged result not moved to output");
`endif

endmodule
